// ===== design/i4dq_pkg.sv =====
// Shared types and constants for the int4 dequant dot product core.
`default_nettype none
package i4dq_pkg;

  localparam int LANES = 8;

  localparam logic [31:0] F32_QNAN    = 32'h7FC0_0000;
  localparam logic [31:0] F32_INF     = 32'h7F80_0000;
  localparam logic [31:0] F32_ONE     = 32'h3F80_0000;
  localparam logic [31:0] F32_NEGZERO = 32'h8000_0000;

  // Unbiased exponent of the wide datapath, covers products of subnormals.
  typedef logic signed [11:0] exp_t;

  localparam exp_t EXP_SUB  = -12'sd149;
  localparam exp_t EXP_BIAS = 12'sd150;

  typedef struct packed {
    logic issue_acc;
    logic capture;
    logic clear;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== design/int4_dequant_dot_product_core.sv =====
// Top level: chunk sequencer, eight FMA lanes, reduction and output register.
// Usage:
//   Input channel (in_valid/in_ready) takes one word per chunk: eight binary32
//   activations, 32 bits of packed offset-8 nibbles, the binary32 scale and
//   last_chunk. Chunks are accumulated per lane until last_chunk is set.
//   Output channel (out_valid/out_ready) gives one binary32 dot_sum per vector.
// Timing:
//   A chunk occupies the lanes for one pass through the 4-stage FMA to
//   dequantize the weight, then a second dependent pass to accumulate. A new
//   chunk is taken in the cycle the lanes capture that accumulate result, so
//   a chunk is taken only once the one before it has finished both passes.
//   A last chunk adds the reduction: three dependent levels through one shared
//   4-stage adder, then the sum lands in the output register.
// Reset:
//   rst_n (synchronous, active low) clears all lane sums to +0, empties the
//   output register and returns the sequencer to idle.
// Stall:
//   The sum waits in the output register. The next vector's chunks are taken
//   meanwhile; only a further finished sum waits until the register frees.
`default_nettype none
module int4_dequant_dot_product_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_act_0,
  input  wire logic [31:0] in_act_1,
  input  wire logic [31:0] in_act_2,
  input  wire logic [31:0] in_act_3,
  input  wire logic [31:0] in_act_4,
  input  wire logic [31:0] in_act_5,
  input  wire logic [31:0] in_act_6,
  input  wire logic [31:0] in_act_7,
  input  wire logic [31:0] in_packed_weights,
  input  wire logic [31:0] in_weight_scale,
  input  wire logic        in_last_chunk,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] out_dot_sum
);
  import i4dq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_MERGE} state_t;

  localparam logic [3:0] RUN_ACC = 4'd4;
  localparam logic [3:0] RUN_CAP = 4'd8;

  state_t      state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_sum_r, out_sum_nxt;

  logic [LANES-1:0][31:0] act_r;
  logic [31:0]            pw_r, scale_r;
  logic                   last_r;

  logic                   in_acc, m_start, m_take, m_valid;
  logic [31:0]            m_res;
  logic [LANES-1:0][31:0] lane_acc;
  lane_ctl_t              ctl;

  assign in_ready = (state_r == S_IDLE) ||
                    ((state_r == S_RUN) && (cnt_r == RUN_CAP) && !last_r);
  assign in_acc   = in_valid && in_ready;
  assign m_take   = (state_r == S_MERGE) && m_valid && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sum_nxt   = out_sum_r;
    m_start       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RUN;
          cnt_nxt   = 4'd0;
        end
      end
      S_RUN: begin
        if (cnt_r == RUN_CAP) begin
          if (last_r) begin
            m_start   = 1'b1;
            state_nxt = S_MERGE;
          end else if (in_acc) begin
            cnt_nxt = 4'd0;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_MERGE: begin
        if (m_take) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = m_res;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_sum_r <= out_sum_nxt;
  end

  // Hold the chunk for both FMA passes
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= {in_act_7, in_act_6, in_act_5, in_act_4,
                  in_act_3, in_act_2, in_act_1, in_act_0};
      pw_r    <= in_packed_weights;
      scale_r <= in_weight_scale;
      last_r  <= in_last_chunk;
    end
  end

  assign ctl.issue_acc = (state_r == S_RUN) && (cnt_r == RUN_ACC);
  assign ctl.capture   = (state_r == S_RUN) && (cnt_r == RUN_CAP);
  assign ctl.clear     = m_take;

  for (genvar e = 0; e < LANES; e++) begin : g_lane
    // Even element takes the high nibble of its byte, odd the low one
    i4dq_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .act   (act_r[e]),
      .nib   (pw_r[8*(e/2) + 4*(1 - e%2) +: 4]),
      .scale (scale_r),
      .acc   (lane_acc[e])
    );
  end

  i4dq_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (m_start),
    .lanes     (lane_acc),
    .ack       (m_take),
    .res_valid (m_valid),
    .res       (m_res)
  );

  assign out_valid   = out_valid_r;
  assign out_dot_sum = out_sum_r;

  a_merge_only_when_waiting : assert property (
    @(posedge clk) disable iff (!rst_n) m_valid |-> (state_r == S_MERGE))
    else $error("reduction result present outside merge wait");

  a_clear_gives_result : assert property (
    @(posedge clk) disable iff (!rst_n) ctl.clear |=> out_valid)
    else $error("lanes cleared without presenting a sum");

  a_run_starts_on_accept : assert property (
    @(posedge clk) disable iff (!rst_n)
    ((state_r == S_RUN) && (cnt_r == 4'd0)) |-> $past(in_valid && in_ready))
    else $error("chunk pass started without an accepted word");

endmodule
`default_nettype wire

// ===== design/i4dq_fma.sv =====
// Four-stage binary32 fused multiply-add, round to nearest even, subnormals kept.
`default_nettype none
module i4dq_fma (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] c,
  output logic      [31:0] y
);
  import i4dq_pkg::*;

  function automatic logic [5:0] msb64(input logic [63:0] v);
    logic [5:0] k;
    k = 6'd0;
    for (int i = 1; i < 64; i++) begin
      if (v[i]) k = 6'(i);
    end
    return k;
  endfunction

  function automatic exp_t unbias(input logic [7:0] ex);
    return (ex == 8'd0) ? EXP_SUB : (exp_t'({4'd0, ex}) - EXP_BIAS);
  endfunction

  // Stage 0: unpack, special cases, mantissa product
  logic        sa, sb, sc, sp;
  logic [7:0]  ea, eb, ec;
  logic [22:0] fa, fb, fc;
  logic        anan, bnan, cnan, ainf, binf, cinf, az, bz, cz;
  logic [23:0] ma, mb;
  logic        spec0;
  logic [31:0] sval0;

  assign {sa, ea, fa} = a;
  assign {sb, eb, fb} = b;
  assign {sc, ec, fc} = c;
  assign sp   = sa ^ sb;
  assign anan = (ea == 8'hFF) && (fa != '0);
  assign bnan = (eb == 8'hFF) && (fb != '0);
  assign cnan = (ec == 8'hFF) && (fc != '0);
  assign ainf = (ea == 8'hFF) && (fa == '0);
  assign binf = (eb == 8'hFF) && (fb == '0);
  assign cinf = (ec == 8'hFF) && (fc == '0);
  assign az   = (ea == 8'h00) && (fa == '0);
  assign bz   = (eb == 8'h00) && (fb == '0);
  assign cz   = (ec == 8'h00) && (fc == '0);
  assign ma   = {(ea != 8'h00), fa};
  assign mb   = {(eb != 8'h00), fb};

  always_comb begin
    spec0 = 1'b1;
    sval0 = F32_QNAN;
    if (anan || bnan || cnan) begin
      sval0 = F32_QNAN;
    end else if ((ainf && bz) || (binf && az)) begin
      sval0 = F32_QNAN;
    end else if (ainf || binf) begin
      sval0 = (cinf && (sc != sp)) ? F32_QNAN : ({sp, 31'd0} | F32_INF);
    end else if (cinf) begin
      sval0 = c;
    end else if (az || bz) begin
      sval0 = cz ? {sp & sc, 31'd0} : c;
    end else begin
      spec0 = 1'b0;
    end
  end

  logic        s0_spec_r, s0_sp_r, s0_sc_r, s0_cz_r;
  logic [31:0] s0_sval_r;
  logic [47:0] s0_mp_r;
  logic [23:0] s0_mc_r;
  exp_t        s0_ep_r, s0_ce_r;

  always_ff @(posedge clk) begin
    s0_spec_r <= spec0;
    s0_sval_r <= sval0;
    s0_mp_r   <= ma * mb;
    s0_ep_r   <= unbias(ea) + unbias(eb);
    s0_mc_r   <= {(ec != 8'h00), fc};
    s0_ce_r   <= unbias(ec);
    s0_sp_r   <= sp;
    s0_sc_r   <= sc;
    s0_cz_r   <= cz;
  end

  // Stage 1: normalize both terms to bit 61
  logic [5:0] shx, shy;
  assign shx = 6'd61 - msb64({16'd0, s0_mp_r});
  assign shy = 6'd61 - msb64({40'd0, s0_mc_r});

  logic        s1_spec_r, s1_sp_r, s1_sc_r, s1_cz_r;
  logic [31:0] s1_sval_r;
  logic [63:0] s1_x_r, s1_y_r;
  exp_t        s1_xe_r, s1_ye_r;

  always_ff @(posedge clk) begin
    s1_spec_r <= s0_spec_r;
    s1_sval_r <= s0_sval_r;
    s1_x_r    <= {16'd0, s0_mp_r} << shx;
    s1_y_r    <= {40'd0, s0_mc_r} << shy;
    s1_xe_r   <= s0_ep_r - exp_t'({6'd0, shx});
    s1_ye_r   <= s0_ce_r - exp_t'({6'd0, shy});
    s1_sp_r   <= s0_sp_r;
    s1_sc_r   <= s0_sc_r;
    s1_cz_r   <= s0_cz_r;
  end

  // Stage 2: align the smaller term with sticky, then add or subtract
  logic [63:0] big, lesser, lesser_al, sum2;
  exp_t        d, e2;
  logic        rs2, xbig;

  always_comb begin
    xbig = (s1_xe_r > s1_ye_r) || ((s1_xe_r == s1_ye_r) && (s1_x_r >= s1_y_r));
    if (xbig) begin
      big = s1_x_r; lesser = s1_y_r; d = s1_xe_r - s1_ye_r; rs2 = s1_sp_r; e2 = s1_xe_r;
    end else begin
      big = s1_y_r; lesser = s1_x_r; d = s1_ye_r - s1_xe_r; rs2 = s1_sc_r; e2 = s1_ye_r;
    end
    if (d >= 12'sd63) begin
      lesser_al = 64'd1;
    end else begin
      lesser_al = (lesser >> d[5:0]) |
                  64'(((lesser & ((64'd1 << d[5:0]) - 64'd1)) != 64'd0));
    end
    sum2 = (s1_sp_r == s1_sc_r) ? (big + lesser_al) : (big - lesser_al);
    // Zero addend: pass the product through alone
    if (s1_cz_r) begin
      sum2 = s1_x_r;
      e2   = s1_xe_r;
      rs2  = s1_sp_r;
    end
  end

  logic        s2_spec_r, s2_rs_r;
  logic [31:0] s2_sval_r;
  logic [63:0] s2_m_r;
  exp_t        s2_e_r;

  always_ff @(posedge clk) begin
    s2_spec_r <= s1_spec_r;
    s2_sval_r <= s1_sval_r;
    s2_m_r    <= sum2;
    s2_e_r    <= e2;
    s2_rs_r   <= rs2;
  end

  // Stage 3: round and pack
  logic [5:0]  k3, amt;
  exp_t        q, s, ef;
  logic [63:0] mant;
  logic        rb, st;
  logic [31:0] packed3;

  always_comb begin
    k3  = msb64(s2_m_r);
    q   = exp_t'({6'd0, k3}) + s2_e_r - 12'sd23;
    if (q < EXP_SUB) q = EXP_SUB;
    s   = q - s2_e_r;
    rb  = 1'b0;
    st  = 1'b0;
    amt = 6'd0;
    if (s <= 12'sd0) begin
      amt  = 6'(-s);
      mant = s2_m_r << amt;
    end else if (s > 12'sd63) begin
      mant = 64'd0;
      st   = 1'b1;
    end else begin
      amt  = 6'(s);
      mant = s2_m_r >> amt;
      rb   = s2_m_r[amt - 6'd1];
      st   = (s2_m_r & ((64'd1 << (amt - 6'd1)) - 64'd1)) != 64'd0;
    end
    if (rb && (st || mant[0])) mant = mant + 64'd1;
    if (mant == 64'h100_0000) begin
      mant = mant >> 1;
      q    = q + 12'sd1;
    end
    ef = q + EXP_BIAS;
    if (s2_m_r == 64'd0) begin
      packed3 = 32'd0;
    end else if (mant >= 64'h80_0000) begin
      if (ef >= 12'sd255) packed3 = {s2_rs_r, 31'd0} | F32_INF;
      else packed3 = {s2_rs_r, ef[7:0], mant[22:0]};
    end else begin
      packed3 = {s2_rs_r, 8'd0, mant[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    y <= s2_spec_r ? s2_sval_r : packed3;
  end

endmodule
`default_nettype wire

// ===== design/i4dq_lane.sv =====
// One lane: dequantize its weight, then fused multiply-add into the lane sum.
`default_nettype none
module i4dq_lane (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire i4dq_pkg::lane_ctl_t ctl,
  input  wire logic [31:0]         act,
  input  wire logic [3:0]          nib,
  input  wire logic [31:0]         scale,
  output logic      [31:0]         acc
);
  import i4dq_pkg::*;

  // Offset-8 nibble as an exact binary32 value
  function automatic logic [31:0] nib_to_f32(input logic [3:0] n);
    logic [31:0] v;
    case (n)
      4'd0:    v = 32'hC100_0000;
      4'd1:    v = 32'hC0E0_0000;
      4'd2:    v = 32'hC0C0_0000;
      4'd3:    v = 32'hC0A0_0000;
      4'd4:    v = 32'hC080_0000;
      4'd5:    v = 32'hC040_0000;
      4'd6:    v = 32'hC000_0000;
      4'd7:    v = 32'hBF80_0000;
      4'd8:    v = 32'h0000_0000;
      4'd9:    v = 32'h3F80_0000;
      4'd10:   v = 32'h4000_0000;
      4'd11:   v = 32'h4040_0000;
      4'd12:   v = 32'h4080_0000;
      4'd13:   v = 32'h40A0_0000;
      4'd14:   v = 32'h40C0_0000;
      default: v = 32'h40E0_0000;
    endcase
    return v;
  endfunction

  logic [31:0] fa, fb, fc, fo;
  logic [31:0] acc_r;

  // Dequant pass by default; the accumulate pass takes the weight straight off the unit
  always_comb begin
    if (ctl.issue_acc) begin
      fa = act;
      fb = fo;
      fc = acc_r;
    end else begin
      fa = nib_to_f32(nib);
      fb = scale;
      fc = F32_NEGZERO;
    end
  end

  i4dq_fma u_fma (
    .clk (clk),
    .a   (fa),
    .b   (fb),
    .c   (fc),
    .y   (fo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      acc_r <= 32'd0;
    end else if (ctl.capture) begin
      acc_r <= fo;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

// ===== design/i4dq_merge.sv =====
// Reduction of the eight lane sums through one shared adder, three levels deep.
`default_nettype none
module i4dq_merge (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [i4dq_pkg::LANES-1:0][31:0]     lanes,
  input  wire logic                                 ack,
  output logic                                      res_valid,
  output logic      [31:0]                          res
);
  import i4dq_pkg::*;

  // Issue steps (ST) and the steps at which each answer is collected (GT)
  localparam logic [4:0] ST_R0   = 5'd0;
  localparam logic [4:0] ST_R1   = 5'd1;
  localparam logic [4:0] ST_R2   = 5'd2;
  localparam logic [4:0] ST_R3   = 5'd3;
  localparam logic [4:0] GT_R0   = 5'd4;
  localparam logic [4:0] GT_R1   = 5'd5;
  localparam logic [4:0] GT_R2   = 5'd6;
  localparam logic [4:0] GT_R3   = 5'd7;
  localparam logic [4:0] ST_S02  = 5'd8;
  localparam logic [4:0] ST_S13  = 5'd9;
  localparam logic [4:0] GT_S02  = 5'd12;
  localparam logic [4:0] GT_S13  = 5'd13;
  localparam logic [4:0] ST_FIN  = 5'd14;
  localparam logic [4:0] GT_FIN  = 5'd18;

  logic        busy_r, valid_r;
  logic [4:0]  cnt_r;
  logic [31:0] rr0_r, rr1_r, rr2_r, rr3_r, res_r;
  logic [31:0] fa, fc, fo;

  always_comb begin
    case (cnt_r)
      ST_R0:   begin fa = lanes[4]; fc = lanes[0]; end
      ST_R1:   begin fa = lanes[5]; fc = lanes[1]; end
      ST_R2:   begin fa = lanes[6]; fc = lanes[2]; end
      ST_R3:   begin fa = lanes[7]; fc = lanes[3]; end
      ST_S02:  begin fa = rr0_r;    fc = rr2_r;    end
      ST_S13:  begin fa = rr1_r;    fc = rr3_r;    end
      ST_FIN:  begin fa = rr0_r;    fc = rr1_r;    end
      default: begin fa = lanes[4]; fc = lanes[0]; end
    endcase
  end

  i4dq_fma u_fma (
    .clk (clk),
    .a   (fa),
    .b   (F32_ONE),
    .c   (fc),
    .y   (fo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      cnt_r   <= 5'd0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        if (cnt_r == GT_FIN) begin
          busy_r  <= 1'b0;
          valid_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
      if (ack) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      case (cnt_r)
        GT_R0:   rr0_r <= fo;
        GT_R1:   rr1_r <= fo;
        GT_R2:   rr2_r <= fo;
        GT_R3:   rr3_r <= fo;
        GT_S02:  rr0_r <= fo;
        GT_S13:  rr1_r <= fo;
        GT_FIN:  res_r <= fo;
        default: ;
      endcase
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire
